FILE: sv/assert_macros.svh
// assertion helpers used by the decoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define EBLD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true outside reset
`define EBLD_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

FILE: sv/ebld_pkg.sv
// ----------------------------------------------------------------------------
// ebld_pkg
// constants and types of the escape-byte lz decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ebld_pkg;

   localparam int BYTE_W      = 8;
   localparam int HIST_DEPTH  = 256;
   localparam int HIST_AW     = $clog2(HIST_DEPTH);
   localparam int FILL_BW     = HIST_AW + 1;
   localparam int BEAT_BYTES  = 4;
   localparam int FILL_W      = $clog2(BEAT_BYTES);
   localparam int COUNT_W     = 3;
   localparam int LEN_W       = BYTE_W;

   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [HIST_AW-1:0] hist_addr_type;
   typedef byte_type           beat_type [BEAT_BYTES];

endpackage

`default_nettype wire

FILE: sv/escape_byte_lz_decoder.sv
// ----------------------------------------------------------------------------
// escape_byte_lz_decoder
// lzss-style decoder with escape-byte tokens and a 256-byte history
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Takes compressed bytes one per item on the req_ channel and returns decoded
// bytes in beats of up to four on the rsp_ channel. A byte other than the
// escape byte (csr_escape_byte, written while idle) is a literal and gives one
// beat of one byte in the cycle after it is taken. Escape then escape gives a
// literal escape byte. Escape, distance d, length L copies L bytes from d back
// (d-1 back when d is above the escape byte); a zero or too large distance
// gives a single error beat, length zero gives nothing. Escape and distance
// bytes give no beat. The history sits in one synchronous memory whose
// single read port delivers one byte per cycle while rsp_ does not stall,
// with the byte just written forwarded for distance one, and the block takes
// no new item until the last byte of the copy is in the output register.
// Stalls on rsp_ pause the copy. frame_end resets the parser and the history
// position after the byte is handled. The history has no clearing pass after
// reset; the distance check keeps copies off unwritten entries.
module escape_byte_lz_decoder (
   input  wire                          clock,
   input  wire                          reset,
   // compressed input
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire  [ebld_pkg::BYTE_W-1:0]  req_in_byte,
   input  wire                          req_frame_end,
   // decoded beats
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic [ebld_pkg::BYTE_W-1:0]  rsp_out_byte0,
   output logic [ebld_pkg::BYTE_W-1:0]  rsp_out_byte1,
   output logic [ebld_pkg::BYTE_W-1:0]  rsp_out_byte2,
   output logic [ebld_pkg::BYTE_W-1:0]  rsp_out_byte3,
   output logic [ebld_pkg::COUNT_W-1:0] rsp_byte_count,
   output logic                         rsp_last_of_run,
   output logic                         rsp_bad_distance,
   // escape byte register
   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire  [ebld_pkg::BYTE_W-1:0]  csr_escape_byte
);

   // parser phases
   localparam logic [1:0] PH_PLAIN = 2'd0;   // expects a plain byte
   localparam logic [1:0] PH_ESC   = 2'd1;   // follows an escape
   localparam logic [1:0] PH_LEN   = 2'd2;   // distance held, waits for length

   // history memory
   ebld_pkg::byte_type hist_mem [ebld_pkg::HIST_DEPTH];
   ebld_pkg::byte_type rdata_ff;

   // parser and history position
   logic [1:0]                      phase_ff, phase_in;
   ebld_pkg::byte_type              esc_ff, esc_in;
   ebld_pkg::byte_type              held_ff, held_in;
   ebld_pkg::hist_addr_type         wp_ff, wp_in;
   logic [ebld_pkg::FILL_BW-1:0]    bw_ff, bw_in;

   // copy engine
   logic                            busy_ff, busy_in;
   logic                            fe_pend_ff, fe_pend_in;
   ebld_pkg::hist_addr_type         rd_ptr_ff, rd_ptr_in;
   logic [ebld_pkg::LEN_W-1:0]      issue_left_ff, issue_left_in;
   logic [ebld_pkg::LEN_W-1:0]      cons_left_ff, cons_left_in;
   logic                            s2_valid_ff, s2_valid_in;
   logic                            fwd_ff, fwd_in;
   ebld_pkg::byte_type              wbyte_ff, wbyte_in;
   logic [ebld_pkg::FILL_W-1:0]     fill_ff, fill_in;
   ebld_pkg::beat_type              beat_ff, beat_in;

   // output register
   logic                            rsp_valid_ff, rsp_valid_in;
   ebld_pkg::beat_type              rsp_bytes_ff, rsp_bytes_in;
   logic [ebld_pkg::COUNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic                            rsp_last_ff, rsp_last_in;
   logic                            rsp_bad_ff, rsp_bad_in;

   // datapath decode
   logic                            out_free;
   logic                            req_accept;
   logic                            is_esc;
   ebld_pkg::byte_type              dist_eff;
   logic                            dist_bad;
   ebld_pkg::byte_type              copy_byte;
   logic                            completes;
   logic                            consume;
   logic                            issue;
   logic                            last_byte;
   logic                            lit;
   logic                            len_tok;
   logic                            err;
   logic                            start;
   logic                            mem_we;
   ebld_pkg::byte_type              mem_wdata;

   // handshakes: output register frees when empty or being taken
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = busy_ff || !out_free;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = !busy_ff;

   // token decode
   assign is_esc   = (req_in_byte == esc_ff);
   assign dist_eff = (held_ff > esc_ff) ? held_ff - 8'd1 : held_ff;
   assign dist_bad = (dist_eff == '0) ||
                     (ebld_pkg::FILL_BW'(dist_eff) > bw_ff);

   assign lit     = req_accept && (((phase_ff == PH_PLAIN) && !is_esc) ||
                                   ((phase_ff == PH_ESC) && is_esc));
   assign len_tok = req_accept && (phase_ff == PH_LEN);
   assign err     = len_tok && (req_in_byte != '0) && dist_bad;
   assign start   = len_tok && (req_in_byte != '0) && !dist_bad;

   // copy pipeline: read issue, then consume (write back and pack into beat)
   assign copy_byte = fwd_ff ? wbyte_ff : rdata_ff;
   assign last_byte = (cons_left_ff == ebld_pkg::LEN_W'(1));
   assign completes = (fill_ff == ebld_pkg::FILL_W'(ebld_pkg::BEAT_BYTES - 1)) || last_byte;
   assign consume   = s2_valid_ff && (!completes || out_free);
   assign issue     = busy_ff && (issue_left_ff != '0) && (!s2_valid_ff || consume);

   // single write port shared by literals and copies, never both at once
   assign mem_we    = lit || consume;
   assign mem_wdata = lit ? req_in_byte : copy_byte;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[wp_ff] <= mem_wdata;
      end
      if (issue) begin
         rdata_ff <= hist_mem[rd_ptr_ff];
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      esc_in        = esc_ff;
      held_in       = held_ff;
      wp_in         = wp_ff;
      bw_in         = bw_ff;
      busy_in       = busy_ff;
      fe_pend_in    = fe_pend_ff;
      rd_ptr_in     = rd_ptr_ff;
      issue_left_in = issue_left_ff;
      cons_left_in  = cons_left_ff;
      s2_valid_in   = s2_valid_ff;
      fwd_in        = fwd_ff;
      wbyte_in      = wbyte_ff;
      fill_in       = fill_ff;
      beat_in       = beat_ff;

      if (csr_valid && csr_ready) begin
         esc_in = csr_escape_byte;
      end

      // parser
      if (req_accept) begin
         case (phase_ff)
            PH_PLAIN: begin
               phase_in = is_esc ? PH_ESC : PH_PLAIN;
            end
            PH_ESC: begin
               if (is_esc) begin
                  phase_in = PH_PLAIN;
               end else begin
                  phase_in = PH_LEN;
                  held_in  = req_in_byte;
               end
            end
            PH_LEN: begin
               phase_in = PH_PLAIN;
            end
            default: begin
               phase_in = PH_PLAIN;
            end
         endcase
         if (req_frame_end) begin
            phase_in = PH_PLAIN;
            held_in  = '0;
         end
      end

      // history position advances with every byte written
      if (mem_we) begin
         wp_in = wp_ff + 1'b1;
         if (bw_ff != ebld_pkg::FILL_BW'(ebld_pkg::HIST_DEPTH)) begin
            bw_in = bw_ff + 1'b1;
         end
      end

      // copy start
      if (start) begin
         busy_in       = 1'b1;
         fe_pend_in    = req_frame_end;
         rd_ptr_in     = wp_ff - ebld_pkg::HIST_AW'(dist_eff);
         issue_left_in = req_in_byte;
         cons_left_in  = req_in_byte;
         fill_in       = '0;
      end

      // read issue; forward when the read hits the entry written this cycle
      if (issue) begin
         rd_ptr_in     = rd_ptr_ff + 1'b1;
         issue_left_in = issue_left_ff - 1'b1;
         s2_valid_in   = 1'b1;
         fwd_in        = consume && (rd_ptr_ff == wp_ff);
      end else if (consume) begin
         s2_valid_in = 1'b0;
      end

      if (consume) begin
         wbyte_in     = copy_byte;
         cons_left_in = cons_left_ff - 1'b1;
         if (completes) begin
            fill_in = '0;
         end else begin
            beat_in[fill_ff] = copy_byte;
            fill_in          = fill_ff + 1'b1;
         end
         if (last_byte) begin
            busy_in = 1'b0;
         end
      end

      // frame end: right away unless the byte starts a copy, after a copy at its last byte
      if (req_accept && req_frame_end && !start) begin
         wp_in = '0;
         bw_in = '0;
      end
      if (consume && last_byte && fe_pend_ff) begin
         wp_in = '0;
         bw_in = '0;
      end
   end

   // output register load
   always_comb begin
      int k;
      rsp_valid_in = rsp_valid_ff;
      rsp_bytes_in = rsp_bytes_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_bad_in   = rsp_bad_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (lit) begin
         rsp_valid_in = 1'b1;
         for (k = 0; k < ebld_pkg::BEAT_BYTES; k++) begin
            rsp_bytes_in[k] = '0;
         end
         rsp_bytes_in[0] = req_in_byte;
         rsp_count_in    = ebld_pkg::COUNT_W'(1);
         rsp_last_in     = 1'b1;
         rsp_bad_in      = 1'b0;
      end else if (err) begin
         rsp_valid_in = 1'b1;
         for (k = 0; k < ebld_pkg::BEAT_BYTES; k++) begin
            rsp_bytes_in[k] = '0;
         end
         rsp_count_in = '0;
         rsp_last_in  = 1'b1;
         rsp_bad_in   = 1'b1;
      end else if (consume && completes) begin
         rsp_valid_in = 1'b1;
         for (k = 0; k < ebld_pkg::BEAT_BYTES; k++) begin
            if (ebld_pkg::FILL_W'(k) < fill_ff) begin
               rsp_bytes_in[k] = beat_ff[k];
            end else if (ebld_pkg::FILL_W'(k) == fill_ff) begin
               rsp_bytes_in[k] = copy_byte;
            end else begin
               rsp_bytes_in[k] = '0;
            end
         end
         rsp_count_in = ebld_pkg::COUNT_W'(fill_ff) + 1'b1;
         rsp_last_in  = last_byte;
         rsp_bad_in   = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_PLAIN;
         esc_ff        <= '0;
         held_ff       <= '0;
         wp_ff         <= '0;
         bw_ff         <= '0;
         busy_ff       <= 1'b0;
         fe_pend_ff    <= 1'b0;
         issue_left_ff <= '0;
         cons_left_ff  <= '0;
         s2_valid_ff   <= 1'b0;
         fwd_ff        <= 1'b0;
         fill_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         esc_ff        <= esc_in;
         held_ff       <= held_in;
         wp_ff         <= wp_in;
         bw_ff         <= bw_in;
         busy_ff       <= busy_in;
         fe_pend_ff    <= fe_pend_in;
         issue_left_ff <= issue_left_in;
         cons_left_ff  <= cons_left_in;
         s2_valid_ff   <= s2_valid_in;
         fwd_ff        <= fwd_in;
         fill_ff       <= fill_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_ptr_ff    <= rd_ptr_in;
      wbyte_ff     <= wbyte_in;
      beat_ff      <= beat_in;
      rsp_bytes_ff <= rsp_bytes_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte0    = rsp_bytes_ff[0];
   assign rsp_out_byte1    = rsp_bytes_ff[1];
   assign rsp_out_byte2    = rsp_bytes_ff[2];
   assign rsp_out_byte3    = rsp_bytes_ff[3];
   assign rsp_byte_count   = rsp_count_ff;
   assign rsp_last_of_run  = rsp_last_ff;
   assign rsp_bad_distance = rsp_bad_ff;

   // checks
   `EBLD_ASSERT(a_busy_blocks_input, clock, reset, busy_ff |-> req_stall, "item taken during copy")
   `EBLD_NEVER(a_one_write_port, clock, reset, lit && consume, "literal and copy write collide")
   `EBLD_ASSERT(a_error_beat_shape, clock, reset, (rsp_valid_ff && rsp_bad_ff) |-> ((rsp_count_ff == '0) && rsp_last_ff), "malformed error beat")
   `EBLD_ASSERT(a_copy_ends, clock, reset, (consume && last_byte) |=> !busy_ff, "copy engine did not stop")

endmodule

`default_nettype wire

FILE: test/tb_escape_byte_lz_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_escape_byte_lz_decoder
// Drives compressed byte streams into the escape-byte lz decoder and checks
// every decoded beat against a cycle-free software decoder kept in a small
// scoreboard. Runs a directed burst and then random token streams under
// several escape byte settings, with random idling on both sides and one long
// receiver hold-off.
// ----------------------------------------------------------------------------

module tb_escape_byte_lz_decoder;

   // no handshake of any kind for this many cycles ends the run
   localparam int STUCK_LIMIT   = 4000;
   // long receiver hold-off, long enough to back the block up into req_stall
   localparam int HOLD_CYCLES   = 300;
   // quiet time before a register write, covers escape and distance bytes
   localparam int SETTLE_CYCLES = 8;
   // random tokens per escape byte setting, roughly two bytes each
   localparam int PHASE_TOKENS  = 55;

   // where the decoder stands inside a token
   typedef enum logic [1:0] {EXPECT_PLAIN, AFTER_ESCAPE, HAVE_DISTANCE} parse_state_type;

   typedef struct {
      ebld_pkg::byte_type           data [ebld_pkg::BEAT_BYTES];
      logic [ebld_pkg::COUNT_W-1:0] count;
      logic                         last;
      logic                         bad;
   } decoded_beat_type;

   // keeps its own copy of the decoder state and the beats still owed
   class lz_decode_scoreboard_type;
      ebld_pkg::byte_type      escape_val;
      parse_state_type         parse_at;
      ebld_pkg::byte_type      held_dist;
      ebld_pkg::byte_type      hist [ebld_pkg::HIST_DEPTH];
      ebld_pkg::hist_addr_type wr_pos;
      int unsigned             written;
      decoded_beat_type        expected_beats [$];
      int unsigned             items_seen;
      int unsigned             beats_seen;
      int unsigned             copies_seen;
      int unsigned             errors_seen;
      int unsigned             fail_count;

      function new();
         escape_val  = '0;
         parse_at    = EXPECT_PLAIN;
         held_dist   = '0;
         wr_pos      = '0;
         written     = 0;
         items_seen  = 0;
         beats_seen  = 0;
         copies_seen = 0;
         errors_seen = 0;
         fail_count  = 0;
         for (int i = 0; i < ebld_pkg::HIST_DEPTH; i++) hist[i] = '0;
      endfunction

      function void set_escape(ebld_pkg::byte_type v);
         escape_val = v;
      endfunction

      function decoded_beat_type fresh_beat();
         decoded_beat_type bt;
         for (int i = 0; i < ebld_pkg::BEAT_BYTES; i++) bt.data[i] = '0;
         bt.count = '0;
         bt.last  = 1'b0;
         bt.bad   = 1'b0;
         return bt;
      endfunction

      function void store_byte(ebld_pkg::byte_type b);
         hist[wr_pos] = b;
         wr_pos++;
         if (written < ebld_pkg::HIST_DEPTH) written++;
      endfunction

      function void push_literal(ebld_pkg::byte_type b);
         decoded_beat_type bt;
         bt = fresh_beat();
         store_byte(b);
         bt.data[0] = b;
         bt.count   = ebld_pkg::COUNT_W'(1);
         bt.last    = 1'b1;
         expected_beats.push_back(bt);
      endfunction

      function void copy_bytes(int unsigned len);
         decoded_beat_type   bt;
         int unsigned        eff_dist;
         int unsigned        fill;
         ebld_pkg::byte_type b;
         bt = fresh_beat();
         if (len == 0) return;
         eff_dist = held_dist;
         if (eff_dist > escape_val) eff_dist--;
         // zero distance or reaching past what this frame wrote
         if (eff_dist == 0 || eff_dist > written) begin
            bt.last = 1'b1;
            bt.bad  = 1'b1;
            expected_beats.push_back(bt);
            errors_seen++;
            return;
         end
         copies_seen++;
         fill = 0;
         for (int unsigned i = 0; i < len; i++) begin
            // byte by byte, so a short distance repeats freshly written bytes
            b = hist[ebld_pkg::hist_addr_type'(wr_pos - eff_dist)];
            store_byte(b);
            bt.data[fill] = b;
            fill++;
            if (fill == ebld_pkg::BEAT_BYTES || i + 1 == len) begin
               bt.count = ebld_pkg::COUNT_W'(fill);
               bt.last  = (i + 1 == len);
               expected_beats.push_back(bt);
               bt   = fresh_beat();
               fill = 0;
            end
         end
      endfunction

      function void note_item(ebld_pkg::byte_type b, logic fe);
         items_seen++;
         case (parse_at)
            AFTER_ESCAPE: begin
               if (b == escape_val) begin
                  push_literal(b);
                  parse_at = EXPECT_PLAIN;
               end else begin
                  held_dist = b;
                  parse_at  = HAVE_DISTANCE;
               end
            end
            HAVE_DISTANCE: begin
               parse_at = EXPECT_PLAIN;
               copy_bytes(b);
            end
            default: begin
               if (b == escape_val) parse_at = AFTER_ESCAPE;
               else push_literal(b);
            end
         endcase
         // frame end drops a half-read token and restarts the history window
         if (fe) begin
            parse_at  = EXPECT_PLAIN;
            held_dist = '0;
            wr_pos    = '0;
            written   = 0;
         end
      endfunction

      function void check_beat(decoded_beat_type got);
         decoded_beat_type want;
         beats_seen++;
         if (expected_beats.size() == 0) begin
            $error("unexpected beat: byte_count %0d bad_distance %0d", got.count, got.bad);
            fail_count++;
            return;
         end
         want = expected_beats.pop_front();
         for (int i = 0; i < ebld_pkg::BEAT_BYTES; i++)
            if (got.data[i] !== want.data[i]) begin
               $error("out_byte%0d expected %0d actual %0d", i, want.data[i], got.data[i]);
               fail_count++;
            end
         if (got.count !== want.count) begin
            $error("byte_count expected %0d actual %0d", want.count, got.count);
            fail_count++;
         end
         if (got.last !== want.last) begin
            $error("last_of_run expected %0d actual %0d", want.last, got.last);
            fail_count++;
         end
         if (got.bad !== want.bad) begin
            $error("bad_distance expected %0d actual %0d", want.bad, got.bad);
            fail_count++;
         end
      endfunction
   endclass

   logic                         clock;
   logic                         reset           = 1'b1;
   logic                         req_valid       = 1'b0;
   logic                         req_stall;
   ebld_pkg::byte_type           req_in_byte     = '0;
   logic                         req_frame_end   = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_stall       = 1'b0;
   ebld_pkg::byte_type           rsp_out_byte0;
   ebld_pkg::byte_type           rsp_out_byte1;
   ebld_pkg::byte_type           rsp_out_byte2;
   ebld_pkg::byte_type           rsp_out_byte3;
   logic [ebld_pkg::COUNT_W-1:0] rsp_byte_count;
   logic                         rsp_last_of_run;
   logic                         rsp_bad_distance;
   logic                         csr_valid       = 1'b0;
   logic                         csr_ready;
   ebld_pkg::byte_type           csr_escape_byte = '0;

   lz_decode_scoreboard_type sb;

   // stimulus side view of the escape byte and of the bytes in the open frame
   ebld_pkg::byte_type esc_now      = '0;
   int unsigned        gen_written  = 0;
   ebld_pkg::byte_type mid_escape   = '0;
   // quiet turns idling off on both sides, hold_request starts the hold-off
   bit                 quiet        = 1'b0;
   bit                 hold_request = 1'b0;
   int unsigned        stuck_cycles = 0;

   escape_byte_lz_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_frame_end    (req_frame_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte0    (rsp_out_byte0),
      .rsp_out_byte1    (rsp_out_byte1),
      .rsp_out_byte2    (rsp_out_byte2),
      .rsp_out_byte3    (rsp_out_byte3),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_bad_distance (rsp_bad_distance),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_escape_byte  (csr_escape_byte)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // idle with a chance of about 13 in a hundred unless a quiet stretch is on
   function automatic bit take_idle();
      return !quiet && ($urandom_range(99) < 13);
   endfunction

   // any byte except the current escape byte
   function automatic ebld_pkg::byte_type plain_byte();
      ebld_pkg::byte_type b;
      b = ebld_pkg::byte_type'($urandom);
      if (b == esc_now) b = ~b;
      return b;
   endfunction

   // bytes written in the open frame, the history window saturates at its depth
   function automatic void grow_frame(int unsigned n);
      gen_written = (gen_written + n > ebld_pkg::HIST_DEPTH) ?
                    ebld_pkg::HIST_DEPTH : gen_written + n;
   endfunction

   // offer one item and hold it until it is taken; valid is left high so the
   // next item follows without a gap unless a random idle comes first
   task automatic send_byte(ebld_pkg::byte_type b, logic fe);
      while (take_idle()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_in_byte   <= b;
      req_frame_end <= fe;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_escape(ebld_pkg::byte_type v);
      csr_valid       <= 1'b1;
      csr_escape_byte <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      esc_now = v;
   endtask

   // stop offering, let every owed beat arrive, then give the block a moment
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic end_frame();
      send_byte(plain_byte(), 1'b1);
      gen_written = 0;
   endtask

   // escape, distance, length; distances are mostly inside the frame,
   // with some bad ones and some zero lengths mixed in
   task automatic send_copy(bit cut);
      int unsigned        kind;
      int unsigned        eff;
      int unsigned        len;
      int unsigned        top;
      int unsigned        near;
      int unsigned        r;
      ebld_pkg::byte_type dist_raw;
      kind = $urandom_range(99);
      if (gen_written == 0 || kind < 8) begin
         // zero effective distance or a distance past the written bytes
         if (gen_written < 254 && $urandom_range(1)) eff = $urandom_range(gen_written + 1, 254);
         else eff = 0;
         len = $urandom_range(1, 8);
      end else if (kind < 14) begin
         eff = $urandom_range(0, 254);
         len = 0;
      end else begin
         top  = (gen_written < 254) ? gen_written : 254;
         near = (top < 4) ? top : 4;
         // short distances overlap the copy with itself
         eff  = $urandom_range(1) ? $urandom_range(1, near) : $urandom_range(1, top);
         r    = $urandom_range(99);
         if (r < 88)      len = $urandom_range(1, 16);
         else if (r < 97) len = $urandom_range(17, 64);
         else             len = $urandom_range(200, 255);
         grow_frame(len);
      end
      // raw distance above the escape byte is taken one shorter
      if (eff == 0)            dist_raw = (esc_now == 0) ? 8'd1 : 8'd0;
      else if (eff < esc_now)  dist_raw = ebld_pkg::byte_type'(eff);
      else                     dist_raw = ebld_pkg::byte_type'(eff + 1);
      send_byte(esc_now, 1'b0);
      send_byte(dist_raw, 1'b0);
      send_byte(ebld_pkg::byte_type'(len), cut);
   endtask

   task automatic send_random_token();
      int unsigned pick;
      bit          cut;
      pick = $urandom_range(99);
      cut  = ($urandom_range(99) < 4);
      if (pick < 42) begin
         send_byte(plain_byte(), cut);
         grow_frame(1);
      end else if (pick < 52) begin
         send_byte(esc_now, 1'b0);
         send_byte(esc_now, cut);
         grow_frame(1);
      end else if (pick < 90) begin
         send_copy(cut);
      end else begin
         // broken token or a stray byte, always closing the frame
         if ($urandom_range(1)) begin
            cut = $urandom_range(1);
            send_byte(esc_now, cut);
            if (!cut) send_byte(ebld_pkg::byte_type'($urandom), 1'b1);
         end else begin
            send_byte(ebld_pkg::byte_type'($urandom), 1'b1);
         end
         cut = 1'b1;
      end
      if (cut) gen_written = 0;
   endtask

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= take_idle();
         end
      end
   end

   // sample every handshake at the edge it completes on
   always @(posedge clock) begin
      decoded_beat_type got;
      bit               moved;
      moved = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got.data[0] = rsp_out_byte0;
            got.data[1] = rsp_out_byte1;
            got.data[2] = rsp_out_byte2;
            got.data[3] = rsp_out_byte3;
            got.count   = rsp_byte_count;
            got.last    = rsp_last_of_run;
            got.bad     = rsp_bad_distance;
            sb.check_beat(got);
            moved = 1'b1;
         end
         if (req_valid && !req_stall) begin
            sb.note_item(req_in_byte, req_frame_end);
            moved = 1'b1;
         end
         if (csr_valid && csr_ready) begin
            sb.set_escape(csr_escape_byte);
            moved = 1'b1;
         end
         stuck_cycles = moved ? 0 : stuck_cycles + 1;
      end
   end

   // watchdog
   initial begin
      wait (stuck_cycles >= STUCK_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // escape byte still at its reset value of zero
      send_byte(8'hff, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h80, 1'b0);
      // escaped literal
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      // raw distance one is taken as zero: error beat
      send_byte(8'h00, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h03, 1'b0);
      // distance two, six bytes: overlapping copy over two beats
      send_byte(8'h00, 1'b0);
      send_byte(8'h03, 1'b0);
      send_byte(8'h06, 1'b0);
      // zero length gives nothing
      send_byte(8'h00, 1'b0);
      send_byte(8'h09, 1'b0);
      send_byte(8'h00, 1'b0);
      // distance past the written bytes
      send_byte(8'h00, 1'b0);
      send_byte(8'hc8, 1'b0);
      send_byte(8'h04, 1'b0);
      // frame end cuts a token after its distance
      send_byte(8'h00, 1'b0);
      send_byte(8'h05, 1'b1);
      // fresh frame has nothing to copy from
      send_byte(8'h00, 1'b0);
      send_byte(8'h02, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h7f, 1'b1);
      settle();

      // top escape value, distance below it, longest copy
      write_escape(8'hff);
      send_byte(8'h42, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'hff, 1'b0);
      gen_written = ebld_pkg::HIST_DEPTH;
      repeat (PHASE_TOKENS) send_random_token();
      end_frame();
      settle();

      write_escape(8'h00);
      repeat (PHASE_TOKENS) send_random_token();
      end_frame();
      settle();

      // random escape; a stretch with no idling, then the long hold-off
      mid_escape = ebld_pkg::byte_type'($urandom_range(1, 254));
      write_escape(mid_escape);
      quiet = 1'b1;
      repeat (PHASE_TOKENS / 2) send_random_token();
      quiet        = 1'b0;
      hold_request = 1'b1;
      repeat (PHASE_TOKENS - PHASE_TOKENS / 2) send_random_token();
      end_frame();
      settle();

      write_escape(8'h80);
      repeat (PHASE_TOKENS) send_random_token();
      end_frame();
      settle();
      repeat (20) @(posedge clock);

      $display("decoded %0d input bytes into %0d beats: %0d copies, %0d bad-distance beats",
               sb.items_seen, sb.beats_seen, sb.copies_seen, sb.errors_seen);
      $display("escape byte 0x00, 0xff, 0x%02h, 0x80; one %0d-cycle receiver hold-off",
               mid_escape, HOLD_CYCLES);
      if (sb.fail_count == 0 && sb.expected_beats.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
